FILE: sv/civ_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// civ_pkg
// Shared types and constants of the settings record validator.
// ----------------------------------------------------------------------------
package civ_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned RestW  = WordW - ByteW;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned StepCntW = 2;

  // record word positions
  localparam logic [PosW-1:0] PosMagic   = 4'd0;
  localparam logic [PosW-1:0] PosVersion = 4'd1;
  localparam logic [PosW-1:0] PosLength  = 4'd2;
  localparam logic [PosW-1:0] PosFlag    = 4'd12;
  localparam logic [PosW-1:0] PosGas     = 4'd13;
  localparam logic [PosW-1:0] PosLast    = 4'd14;

  // FNV-1a 32
  localparam logic [WordW-1:0] FnvBasis = 32'd2166136261;
  localparam logic [WordW-1:0] FnvPrime = 32'd16777619;

  // register reset values
  localparam logic [WordW-1:0] RstMagic     = 32'h5043_4647;
  localparam logic [WordW-1:0] RstVersion   = 32'd1;
  localparam logic [WordW-1:0] RstLength    = 32'd60;
  localparam logic [WordW-1:0] RstGasFirst  = 32'd0;
  localparam logic [WordW-1:0] RstGasSecond = 32'd1;

  // index of the last byte step in the HASH state, after the byte hashed on the accept cycle
  localparam logic [StepCntW-1:0] LastStep = 2'd2;

  typedef enum logic [2:0] {
    FAIL_NONE,
    FAIL_MAGIC,
    FAIL_VERSION,
    FAIL_LENGTH,
    FAIL_FLAG,
    FAIL_GAS,
    FAIL_CHECKSUM
  } fail_e;

  typedef enum logic [2:0] {
    REG_MAGIC,
    REG_VERSION,
    REG_LENGTH,
    REG_GAS_FIRST,
    REG_GAS_SECOND
  } reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_HASH
  } state_e;

  typedef struct packed {
    logic [WordW-1:0] magic;
    logic [WordW-1:0] version;
    logic [WordW-1:0] length;
    logic [WordW-1:0] gas_first;
    logic [WordW-1:0] gas_second;
  } cfg_t;

  typedef struct packed {
    logic load;  // take the accepted word, hash its low byte
    logic step;  // hash the next held byte
  } cmd_t;

  typedef struct packed {
    logic final_word;  // offered word closes the record
    logic last_pos;    // next word position is the checksum word
  } sts_t;

endpackage
`default_nettype wire

FILE: sv/civ_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// civ_in_if / civ_out_if
// Valid/ready channels for record words and for check results.
// ----------------------------------------------------------------------------
interface civ_in_if;
  logic                      valid;
  logic                      ready;
  logic [civ_pkg::WordW-1:0] image_word;
  logic                      frame_start;

  modport source (output valid, output image_word, output frame_start, input ready);
  modport sink   (input valid, input image_word, input frame_start, output ready);
endinterface

interface civ_out_if;
  logic                      valid;
  logic                      ready;
  logic                      image_valid;
  logic [2:0]                fail_reason;
  logic [civ_pkg::WordW-1:0] computed_hash;

  modport source (output valid, output image_valid, output fail_reason,
                  output computed_hash, input ready);
  modport sink   (input valid, input image_valid, input fail_reason,
                  input computed_hash, output ready);
endinterface
`default_nettype wire

FILE: sv/civ_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// civ_ctrl
// Sequencer: accepts a word, walks the byte steps, owns the result valid.
// ----------------------------------------------------------------------------
module civ_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire civ_pkg::sts_t   sts_i,
  output civ_pkg::cmd_t        cmd_o
);

  civ_pkg::state_e                state_q, state_d;
  logic [civ_pkg::StepCntW-1:0]   cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic                           in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= civ_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    // a checksum word needs a free result slot
    in_ready_o  = (state_q == civ_pkg::ST_IDLE) && !(sts_i.last_pos && out_valid_q);
    in_fire     = in_valid_i && in_ready_o;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      civ_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_o.load = 1'b1;
          if (sts_i.final_word) begin
            out_valid_d = 1'b1;
          end else begin
            state_d = civ_pkg::ST_HASH;
            cnt_d   = '0;
          end
        end
      end
      civ_pkg::ST_HASH: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == civ_pkg::LastStep) begin
          state_d = civ_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = civ_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_no_accept_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == civ_pkg::ST_HASH |-> !in_ready_o)
    else $error("word accepted while bytes still hashing");

  a_final_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && sts_i.final_word |-> !out_valid_q)
    else $error("result slot overwritten");

  a_final_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && sts_i.final_word |=> out_valid_q)
    else $error("checksum word produced no result");

  a_hash_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == civ_pkg::ST_HASH && cnt_q == civ_pkg::LastStep |=>
      state_q == civ_pkg::ST_IDLE)
    else $error("byte sequencer overran");

endmodule
`default_nettype wire

FILE: sv/civ_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// civ_datapath
// Record position, field checks, FNV-1a byte hash and the result register.
// ----------------------------------------------------------------------------
module civ_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire civ_pkg::cfg_t             cfg_i,
  input  wire logic [civ_pkg::WordW-1:0] image_word_i,
  input  wire logic                      frame_start_i,
  input  wire civ_pkg::cmd_t             cmd_i,
  output civ_pkg::sts_t                  sts_o,
  output logic                           image_valid_o,
  output logic [2:0]                     fail_reason_o,
  output logic [civ_pkg::WordW-1:0]      computed_hash_o
);

  logic [civ_pkg::PosW-1:0]  pos_q;
  logic [civ_pkg::WordW-1:0] hash_q;
  civ_pkg::fail_e            fail_q;
  logic [civ_pkg::RestW-1:0] rest_q;
  civ_pkg::fail_e            reason_q;
  logic [civ_pkg::WordW-1:0] res_hash_q;

  logic [civ_pkg::PosW-1:0]  eff_pos;
  logic [civ_pkg::WordW-1:0] eff_hash;
  civ_pkg::fail_e            eff_fail;
  civ_pkg::fail_e            cand;
  civ_pkg::fail_e            fail_upd;
  civ_pkg::fail_e            final_reason;
  logic [civ_pkg::WordW-1:0] mult_a;
  logic [civ_pkg::WordW-1:0] prod;

  // frame start drops the partial record
  assign eff_pos  = frame_start_i ? '0 : pos_q;
  assign eff_hash = frame_start_i ? civ_pkg::FnvBasis : hash_q;
  assign eff_fail = frame_start_i ? civ_pkg::FAIL_NONE : fail_q;

  assign sts_o.last_pos   = (pos_q == civ_pkg::PosLast);
  assign sts_o.final_word = (eff_pos == civ_pkg::PosLast);

  always_comb begin
    cand = civ_pkg::FAIL_NONE;
    case (eff_pos)
      civ_pkg::PosMagic:   if (image_word_i != cfg_i.magic)   cand = civ_pkg::FAIL_MAGIC;
      civ_pkg::PosVersion: if (image_word_i != cfg_i.version) cand = civ_pkg::FAIL_VERSION;
      civ_pkg::PosLength:  if (image_word_i != cfg_i.length)  cand = civ_pkg::FAIL_LENGTH;
      civ_pkg::PosFlag:    if (|image_word_i[civ_pkg::WordW-1:1]) cand = civ_pkg::FAIL_FLAG;
      civ_pkg::PosGas: begin
        if (image_word_i != cfg_i.gas_first && image_word_i != cfg_i.gas_second) begin
          cand = civ_pkg::FAIL_GAS;
        end
      end
      default: cand = civ_pkg::FAIL_NONE;
    endcase
    fail_upd = (eff_fail == civ_pkg::FAIL_NONE) ? cand : eff_fail;

    if (eff_fail != civ_pkg::FAIL_NONE) begin
      final_reason = eff_fail;
    end else if (image_word_i != eff_hash) begin
      final_reason = civ_pkg::FAIL_CHECKSUM;
    end else begin
      final_reason = civ_pkg::FAIL_NONE;
    end

    // one byte per cycle: xor, then multiply by the prime
    if (cmd_i.load) begin
      mult_a = eff_hash ^ {{civ_pkg::RestW{1'b0}}, image_word_i[civ_pkg::ByteW-1:0]};
    end else begin
      mult_a = hash_q ^ {{civ_pkg::RestW{1'b0}}, rest_q[civ_pkg::ByteW-1:0]};
    end
    prod = civ_pkg::WordW'(mult_a * civ_pkg::FnvPrime);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hash_q <= civ_pkg::FnvBasis;
      fail_q <= civ_pkg::FAIL_NONE;
    end else if (cmd_i.load) begin
      if (sts_o.final_word) begin
        pos_q  <= '0;
        hash_q <= civ_pkg::FnvBasis;
        fail_q <= civ_pkg::FAIL_NONE;
      end else begin
        pos_q  <= eff_pos + 1'b1;
        hash_q <= prod;
        fail_q <= fail_upd;
      end
    end else if (cmd_i.step) begin
      hash_q <= prod;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rest_q <= image_word_i[civ_pkg::WordW-1:civ_pkg::ByteW];
      if (sts_o.final_word) begin
        reason_q   <= final_reason;
        res_hash_q <= eff_hash;
      end
    end else if (cmd_i.step) begin
      rest_q <= rest_q >> civ_pkg::ByteW;
    end
  end

  assign image_valid_o   = (reason_q == civ_pkg::FAIL_NONE);
  assign fail_reason_o   = reason_q;
  assign computed_hash_o = res_hash_q;

endmodule
`default_nettype wire

FILE: sv/config_image_validator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// config_image_validator
// Checks a 15-word settings record: header fields, flag, gas code and an
// FNV-1a 32 hash over words 0..13 compared against word 14.
// ----------------------------------------------------------------------------
//  port      dir  kind        payload
//  img_i     in   valid/ready image_word[31:0], frame_start
//  img_o     out  valid/ready image_valid, fail_reason[2:0], computed_hash[31:0]
//  APB       in   apb write   5 registers at byte offsets 0,4,8,12,16
//
//  Words 0..13: the accept cycle hashes byte 0, then the HASH state hashes
//  bytes 1..3 through the shared 32x32 prime multiplier. Word 14 loads the
//  result register on acceptance. Any word offered while word 14 is due,
//  a frame start too, waits while an earlier result is still held; words
//  at other positions do not.
//  Reset restores the register defaults and starts at word zero.
// ----------------------------------------------------------------------------
module config_image_validator (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  civ_in_if.sink                         img_i,
  civ_out_if.source                      img_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [civ_pkg::AddrW-1:0] paddr,
  input  wire logic [civ_pkg::WordW-1:0] pwdata,
  output logic [civ_pkg::WordW-1:0]      prdata,
  output logic                           pready
);

  civ_pkg::cfg_t  cfg_q;
  civ_pkg::reg_e  reg_sel;
  civ_pkg::cmd_t  cmd;
  civ_pkg::sts_t  sts;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_sel = civ_pkg::reg_e'(paddr[civ_pkg::AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic      <= civ_pkg::RstMagic;
      cfg_q.version    <= civ_pkg::RstVersion;
      cfg_q.length     <= civ_pkg::RstLength;
      cfg_q.gas_first  <= civ_pkg::RstGasFirst;
      cfg_q.gas_second <= civ_pkg::RstGasSecond;
    end else if (wr_en) begin
      case (reg_sel)
        civ_pkg::REG_MAGIC:      cfg_q.magic      <= pwdata;
        civ_pkg::REG_VERSION:    cfg_q.version    <= pwdata;
        civ_pkg::REG_LENGTH:     cfg_q.length     <= pwdata;
        civ_pkg::REG_GAS_FIRST:  cfg_q.gas_first  <= pwdata;
        civ_pkg::REG_GAS_SECOND: cfg_q.gas_second <= pwdata;
        default: ;  // drop writes beyond the map
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      civ_pkg::REG_MAGIC:      prdata = cfg_q.magic;
      civ_pkg::REG_VERSION:    prdata = cfg_q.version;
      civ_pkg::REG_LENGTH:     prdata = cfg_q.length;
      civ_pkg::REG_GAS_FIRST:  prdata = cfg_q.gas_first;
      civ_pkg::REG_GAS_SECOND: prdata = cfg_q.gas_second;
      default:                 prdata = '0;
    endcase
  end

  civ_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (img_i.valid),
    .in_ready_o  (img_i.ready),
    .out_valid_o (img_o.valid),
    .out_ready_i (img_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  civ_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .image_word_i    (img_i.image_word),
    .frame_start_i   (img_i.frame_start),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .image_valid_o   (img_o.image_valid),
    .fail_reason_o   (img_o.fail_reason),
    .computed_hash_o (img_o.computed_hash)
  );

endmodule
`default_nettype wire

FILE: tb/civ_record_checker.sv
// ----------------------------------------------------------------------------
// civ_record_checker
// Watches the record word channel, the result channel and the register port.
// It keeps its own copy of the settings and of the record state, predicts the
// verdict for every closed record and compares each result beat with it.
// ----------------------------------------------------------------------------
module civ_record_checker
  import civ_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  civ_in_if                img_in,
  civ_out_if               img_out,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [WordW-1:0] pwdata,
  output int               fail_count_o,
  output int               due_count_o
);

  typedef struct packed {
    logic             ok;
    fail_e            reason;
    logic [WordW-1:0] hash;
  } verdict_t;

  verdict_t         verdicts_due[$];
  cfg_t             cfg;
  logic [PosW-1:0]  rec_pos;
  logic [WordW-1:0] rec_hash;
  fail_e            rec_fail;
  int               fails = 0;

  function automatic logic [WordW-1:0] fnv_fold(input logic [WordW-1:0] h,
                                                input logic [WordW-1:0] w);
    logic [WordW-1:0] acc;
    int b;
    acc = h;
    for (b = 0; b < 4; b++) begin
      acc = (acc ^ {24'd0, w[8*b +: 8]}) * FnvPrime;
    end
    return acc;
  endfunction

  function automatic void restart_record();
    rec_pos  = PosMagic;
    rec_hash = FnvBasis;
    rec_fail = FAIL_NONE;
  endfunction

  // keep only the first failing check
  function automatic void flag_fault(input fail_e f);
    if (rec_fail == FAIL_NONE) rec_fail = f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : tracker
    verdict_t         v;
    logic [WordW-1:0] w;
    if (!rst_ni) begin
      cfg = '{magic: RstMagic, version: RstVersion, length: RstLength,
              gas_first: RstGasFirst, gas_second: RstGasSecond};
      restart_record();
      verdicts_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[AddrW-1:2]))
          REG_MAGIC:      cfg.magic = pwdata;
          REG_VERSION:    cfg.version = pwdata;
          REG_LENGTH:     cfg.length = pwdata;
          REG_GAS_FIRST:  cfg.gas_first = pwdata;
          REG_GAS_SECOND: cfg.gas_second = pwdata;
          default: ;
        endcase
      end

      if (img_in.valid && img_in.ready) begin
        w = img_in.image_word;
        if (img_in.frame_start) restart_record();
        if (rec_pos == PosLast) begin
          if (w != rec_hash) flag_fault(FAIL_CHECKSUM);
          v.ok     = (rec_fail == FAIL_NONE);
          v.reason = rec_fail;
          v.hash   = rec_hash;
          verdicts_due.push_back(v);
          restart_record();
        end else begin
          case (rec_pos)
            PosMagic:   if (w != cfg.magic) flag_fault(FAIL_MAGIC);
            PosVersion: if (w != cfg.version) flag_fault(FAIL_VERSION);
            PosLength:  if (w != cfg.length) flag_fault(FAIL_LENGTH);
            PosFlag:    if (w > 1) flag_fault(FAIL_FLAG);
            PosGas: begin
              if (w != cfg.gas_first && w != cfg.gas_second) flag_fault(FAIL_GAS);
            end
            default: ;
          endcase
          rec_hash = fnv_fold(rec_hash, w);
          rec_pos  = rec_pos + 1'b1;
        end
      end

      if (img_out.valid && img_out.ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result beat: image_valid %0b fail_reason %0d hash %h",
                   $time, img_out.image_valid, img_out.fail_reason, img_out.computed_hash);
          fails++;
        end else begin
          v = verdicts_due.pop_front();
          if (img_out.image_valid !== v.ok) begin
            $display("%0t: image_valid expected %0b actual %0b",
                     $time, v.ok, img_out.image_valid);
            fails++;
          end
          if (img_out.fail_reason !== v.reason) begin
            $display("%0t: fail_reason expected %0d actual %0d",
                     $time, v.reason, img_out.fail_reason);
            fails++;
          end
          if (img_out.computed_hash !== v.hash) begin
            $display("%0t: computed_hash expected %h actual %h",
                     $time, v.hash, img_out.computed_hash);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    due_count_o  <= verdicts_due.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives settings records into the validator: a short directed opening, then
// phases of random records under different register settings, with faults,
// cut-off records and stray words mixed in. Both channels idle at random and
// the result side holds off once for a long stretch. The checker instance
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import civ_pkg::*;

  localparam int NumRegs       = REG_GAS_SECOND + 1;
  localparam int RecWords      = PosLast + 1;
  localparam int SettleCycles  = 8;
  localparam int SqueezeCycles = 400;
  localparam int WatchdogLimit = 4000;
  localparam int PhaseWords    = 190;

  typedef logic [WordW-1:0] record_t [RecWords];

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [WordW-1:0] pwdata;
  logic [WordW-1:0] prdata;
  logic             pready;

  int   chk_fails;
  int   chk_due;
  int   in_pace;
  int   words_sent;
  int   squeeze_asks;
  int   squeeze_done;
  int   quiet_cycles;
  cfg_t cur_cfg;

  civ_in_if  img_in ();
  civ_out_if img_out ();

  config_image_validator dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .img_i   (img_in),
    .img_o   (img_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  civ_record_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .img_in       (img_in),
    .img_out      (img_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count_o (chk_fails),
    .due_count_o  (chk_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap(input int pace);
    case (pace)
      0:       return 0;
      1:       return int'($urandom_range(0, 19));
      default: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 19)) : 0;
    endcase
  endfunction

  function automatic logic [AddrW-1:0] reg_addr(input int idx);
    return AddrW'(idx << 2);
  endfunction

  // checksum word that makes a record pass
  function automatic logic [WordW-1:0] seal_record(input record_t rec);
    logic [WordW-1:0] h;
    int k, b;
    h = FnvBasis;
    for (k = 0; k < PosLast; k++) begin
      for (b = 0; b < 4; b++) begin
        h = (h ^ {24'd0, rec[k][8*b +: 8]}) * FnvPrime;
      end
    end
    return h;
  endfunction

  task automatic send_word(input logic [WordW-1:0] w, input logic start);
    int gap;
    gap = draw_gap(in_pace);
    @(negedge clk);
    if (gap > 0) begin
      img_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    img_in.valid       <= 1'b1;
    img_in.image_word  <= w;
    img_in.frame_start <= start;
    do @(posedge clk); while (!img_in.ready);
    words_sent++;
  endtask

  // drop valid, wait for every verdict, then let the hashing tail finish
  task automatic settle();
    @(negedge clk);
    img_in.valid <= 1'b0;
    while (chk_due != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic reg_write(input logic [AddrW-1:0] addr, input logic [WordW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input cfg_t c);
    reg_write(reg_addr(REG_MAGIC), c.magic);
    reg_write(reg_addr(REG_VERSION), c.version);
    reg_write(reg_addr(REG_LENGTH), c.length);
    reg_write(reg_addr(REG_GAS_FIRST), c.gas_first);
    reg_write(reg_addr(REG_GAS_SECOND), c.gas_second);
    // past the register file: must change nothing
    reg_write(reg_addr(NumRegs + int'($urandom_range(0, 2))), $urandom());
    cur_cfg = c;
  endtask

  task automatic send_record();
    record_t rec;
    int      k, faults, cut;
    logic    seal_bad, lead;
    fail_e   kind;
    rec[PosMagic]   = cur_cfg.magic;
    rec[PosVersion] = cur_cfg.version;
    rec[PosLength]  = cur_cfg.length;
    for (k = PosLength + 1; k < PosFlag; k++) rec[k] = $urandom();
    rec[PosFlag] = $urandom_range(0, 1);
    rec[PosGas]  = $urandom_range(0, 1) ? cur_cfg.gas_first : cur_cfg.gas_second;
    seal_bad = 1'b0;
    faults = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 2)) : 0;
    repeat (faults) begin
      kind = fail_e'($urandom_range(FAIL_MAGIC, FAIL_CHECKSUM));
      case (kind)
        FAIL_MAGIC:   rec[PosMagic] ^= $urandom_range(1, 32'hFFFF_FFFF);
        FAIL_VERSION: rec[PosVersion] ^= $urandom_range(1, 32'hFFFF_FFFF);
        FAIL_LENGTH:  rec[PosLength] ^= $urandom_range(1, 32'hFFFF_FFFF);
        FAIL_FLAG:    rec[PosFlag] = $urandom_range(2, 32'hFFFF_FFFF);
        FAIL_GAS: begin
          do rec[PosGas] = $urandom();
          while (rec[PosGas] == cur_cfg.gas_first || rec[PosGas] == cur_cfg.gas_second);
        end
        default:      seal_bad = 1'b1;
      endcase
    end
    rec[PosLast] = seal_record(rec);
    if (seal_bad) rec[PosLast] ^= $urandom_range(1, 32'hFFFF_FFFF);

    in_pace = $urandom_range(0, 2);
    cut  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, PosLast)) : RecWords;
    lead = ($urandom_range(0, 5) != 0);
    for (k = 0; k < cut; k++) send_word(rec[k], (k == 0) ? lead : 1'b0);
    // stray words between records
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) send_word($urandom(), $urandom_range(0, 1));
    end
  endtask

  initial begin : result_sink
    int stall, taken, pace;
    taken = 0;
    pace  = 0;
    @(posedge rst_n);
    forever begin
      if (squeeze_asks > squeeze_done) begin
        stall = SqueezeCycles;
        squeeze_done++;
      end else begin
        if (taken % 6 == 0) pace = $urandom_range(0, 2);
        stall = draw_gap(pace);
      end
      if (stall > 0) begin
        @(negedge clk);
        img_out.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        img_out.ready <= 1'b1;
      end
      do @(posedge clk); while (!(img_out.valid && img_out.ready));
      taken++;
    end
  end

  always @(posedge clk) begin
    if ((img_in.valid && img_in.ready) || (img_out.valid && img_out.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    record_t          demo;
    cfg_t             plan;
    logic [WordW-1:0] g;
    int               k, phase, recs, phase_end;
    img_in.valid       = 1'b0;
    img_in.image_word  = '0;
    img_in.frame_start = 1'b0;
    img_out.ready      = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    quiet_cycles       = 0;
    words_sent         = 0;
    squeeze_asks       = 0;
    squeeze_done       = 0;
    in_pace            = 1;
    cur_cfg = '{magic: RstMagic, version: RstVersion, length: RstLength,
                gas_first: RstGasFirst, gas_second: RstGasSecond};
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // partial record, dropped by the restart below
    send_word(cur_cfg.magic, 1'b1);
    send_word('1, 1'b0);
    send_word('0, 1'b0);

    // passing record whose gas code becomes legal only by a write halfway
    demo[PosMagic]   = cur_cfg.magic;
    demo[PosVersion] = cur_cfg.version;
    demo[PosLength]  = cur_cfg.length;
    for (k = PosLength + 1; k < PosFlag; k++) demo[k] = k[0] ? '1 : '0;
    demo[PosFlag] = 32'd1;
    demo[PosGas]  = '1;
    demo[PosLast] = seal_record(demo);
    for (k = 0; k <= 5; k++) send_word(demo[k], k == 0);
    settle();
    reg_write(reg_addr(REG_GAS_SECOND), '1);
    cur_cfg.gas_second = '1;
    for (k = 6; k < RecWords; k++) send_word(demo[k], 1'b0);

    // next words open a new record without a start mark
    send_word(cur_cfg.magic, 1'b0);
    send_word(cur_cfg.version, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h8000_0001, 1'b0);

    for (phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        settle();
        g = $urandom();
        case (phase)
          1:       plan = '0;
          2:       plan = '1;
          3:       plan = '{magic: RstMagic, version: RstVersion, length: RstLength,
                            gas_first: RstGasFirst, gas_second: RstGasSecond};
          4:       plan = '{magic: $urandom(), version: $urandom(), length: $urandom(),
                            gas_first: $urandom(), gas_second: $urandom()};
          default: plan = '{magic: $urandom(), version: $urandom(), length: $urandom(),
                            gas_first: g, gas_second: g};
        endcase
        apply_setting(plan);
      end
      recs = 0;
      phase_end = words_sent + PhaseWords;
      while (words_sent < phase_end) begin
        // hold results off while records keep coming
        if (phase == 2 && recs == 3) squeeze_asks++;
        send_record();
        recs++;
      end
    end

    settle();
    if (chk_fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
